/* hw/rtl/array_table_engine_macros.svh */
// assertion macros for the array table engine
`ifndef ARRAY_TABLE_ENGINE_MACROS_SVH
`define ARRAY_TABLE_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define ATE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ATE_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATE_ASSERT(label, clk, rst, prop, msg)
`define ATE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/ate_pkg.sv */
// shared types, codes and constants of the array table engine
`default_nettype none
package ate_pkg;
   localparam int unsigned DEPTH_DEFAULT = 32;

   typedef enum logic [3:0] {
      MODE_CLEAR = 4'd0, MODE_APPEND = 4'd1, MODE_DELETE = 4'd2, MODE_READ = 4'd3,
      MODE_MINMAX = 4'd4, MODE_SUM = 4'd5, MODE_SEARCH = 4'd6, MODE_PRIMES = 4'd7,
      MODE_SORT_DESC = 4'd8, MODE_SORT_ASC = 4'd9
   } mode_type;

   localparam logic [1:0] KIND_ELEMENT = 2'd0;
   localparam logic [1:0] KIND_MATCH = 2'd1;
   localparam logic [1:0] KIND_FINAL = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NOT_LOADED = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_BAD_POS = 2'd3;

   typedef struct packed {
      logic [3:0] mode;
      logic signed [31:0] value;
      logic [5:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic signed [31:0] element;
      logic [5:0] match_position;
      logic [1:0] status;
      logic signed [31:0] minimum;
      logic signed [31:0] maximum;
      logic signed [31:0] total;
      logic found;
      logic [5:0] count;
      logic last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_DEL_RD, ST_DEL_WR, ST_SCAN_RD, ST_SCAN_EVAL,
      ST_PRIME_DIV, ST_EMIT, ST_SORT_RDKEY, ST_SORT_RDPREV, ST_SORT_CMP,
      ST_SORT_PLACE, ST_FINAL
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic clear_all;
      logic do_append;
      logic set_i_pos;    // i <= position-1
      logic clr_i;
      logic inc_i;
      logic addr_next;    // addr <= i+1
      logic set_addr_j1;  // addr <= j-1
      logic set_addr_j2;  // addr <= j-2
      logic wr_shift;     // store[i] <= rd_data, i++
      logic dec_count;
      logic accum;
      logic prime_init;
      logic prime_step;
      logic emit_load;
      logic set_j_i;      // j <= i
      logic sort_key;     // key <= rd_data
      logic sort_move;    // store[j] <= rd_data, j--
      logic sort_place;   // store[j] <= key
      logic final_load;
      logic set_status;
      logic [1:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [3:0] mode;
      logic loaded;
      logic full;
      logic pos_bad;
      logic i_done;        // i >= n
      logic i_last_shift;  // i+1 >= n
      logic j_zero;
      logic j_one;
      logic move;
      logic hit;           // search hit or prime candidate > 1
      logic prime_done;
      logic prime_yes;
      logic rsp_free;
   } stat_type;
endpackage
`default_nettype wire

/* hw/rtl/ate_datapath.sv */
// datapath: element memory, counters, prime divider and result register
`default_nettype none
module ate_datapath #(
   parameter int unsigned DEPTH = ate_pkg::DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ate_pkg::req_type req_word,
   input  wire ate_pkg::cmd_type cmd,
   output ate_pkg::stat_type stat,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output ate_pkg::rsp_type rsp_word
);
   import ate_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] addr;
   logic [AW-1:0] wr_addr;
   logic [31:0] wr_data;
   logic wr_en;
   req_type req_ff;
   logic [5:0] count_ff, i_ff, j_ff;
   logic loaded_ff;
   logic [31:0] key_ff, min_ff, max_ff, sum_ff;
   logic found_ff;
   logic [1:0] status_ff;
   // prime unit: restoring divider by j
   logic [31:0] pv_ff, rem_ff, quo_ff;
   logic [16:0] pj_ff;
   logic [4:0] pb_ff;
   logic pbusy_ff, pres_ff, pdone_ff;
   logic [32:0] trial;
   logic [31:0] rem_in;
   logic [33:0] jsq;
   logic rvalid_ff;
   rsp_type rsp_ff, rsp_in;
   logic [5:0] n;

   assign n = count_ff;

   always_comb begin
      if (cmd.set_addr_j1) addr = AW'(j_ff - 6'd1);
      else if (cmd.set_addr_j2) addr = AW'(j_ff - 6'd2);
      else if (cmd.addr_next || cmd.inc_i) addr = AW'(i_ff + 6'd1);
      else addr = i_ff[AW-1:0];
   end

   always_comb begin
      wr_en = cmd.do_append || cmd.wr_shift || cmd.sort_move || cmd.sort_place;
      wr_addr = j_ff[AW-1:0];
      wr_data = key_ff;
      if (cmd.do_append) begin
         wr_addr = count_ff[AW-1:0];
         wr_data = req_ff.value;
      end else if (cmd.wr_shift) begin
         wr_addr = i_ff[AW-1:0];
         wr_data = rd_data_ff;
      end else if (cmd.sort_move) begin
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   assign trial = {rem_ff, quo_ff[31]} - {16'd0, pj_ff};
   assign rem_in = trial[32] ? {rem_ff[30:0], quo_ff[31]} : trial[31:0];
   assign jsq = {17'd0, pj_ff} * {17'd0, pj_ff};

   always_ff @(posedge clock) begin
      if (cmd.latch_req) req_ff <= req_word;
      if (cmd.set_i_pos) i_ff <= req_ff.position - 6'd1;
      else if (cmd.clr_i) i_ff <= '0;
      else if (cmd.inc_i || cmd.wr_shift) i_ff <= i_ff + 6'd1;
      if (cmd.set_j_i) j_ff <= i_ff;
      else if (cmd.sort_move) j_ff <= j_ff - 6'd1;
      if (cmd.sort_key) key_ff <= rd_data_ff;
      if (cmd.latch_req) begin
         sum_ff <= '0; found_ff <= 1'b0; status_ff <= STATUS_OK;
         min_ff <= '0; max_ff <= '0;
      end else begin
         if (cmd.set_status) status_ff <= cmd.status;
         if (cmd.accum) begin
            sum_ff <= sum_ff + rd_data_ff;
            if (i_ff == 6'd0 || $signed(rd_data_ff) < $signed(min_ff)) min_ff <= rd_data_ff;
            if (i_ff == 6'd0 || $signed(rd_data_ff) > $signed(max_ff)) max_ff <= rd_data_ff;
         end
         if (cmd.emit_load && (req_ff.mode == MODE_SEARCH || req_ff.mode == MODE_PRIMES))
            found_ff <= 1'b1;
      end
      // prime test of rd_data: for j while j*j<=v, divide v by j bit-serially
      if (cmd.prime_init) begin
         pv_ff <= rd_data_ff; pj_ff <= 17'd2;
         pbusy_ff <= 1'b0; pdone_ff <= 1'b0; pres_ff <= 1'b0;
      end else if (cmd.prime_step && !pdone_ff) begin
         if (!pbusy_ff) begin
            if (jsq > {2'd0, pv_ff}) begin pdone_ff <= 1'b1; pres_ff <= 1'b1; end
            else begin
               pbusy_ff <= 1'b1; pb_ff <= '0; rem_ff <= '0; quo_ff <= pv_ff;
            end
         end else begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[30:0], 1'b0};
            pb_ff <= pb_ff + 5'd1;
            if (pb_ff == 5'd31) begin
               pbusy_ff <= 1'b0;
               if (rem_in == 32'd0) pdone_ff <= 1'b1;
               else pj_ff <= pj_ff + 17'd1;
            end
         end
      end
      if (reset) begin
         count_ff <= '0; loaded_ff <= 1'b0;
      end else begin
         if (cmd.clear_all) begin count_ff <= '0; loaded_ff <= 1'b1; end
         else if (cmd.do_append) count_ff <= count_ff + 6'd1;
         else if (cmd.dec_count) count_ff <= count_ff - 6'd1;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.emit_load) begin
         if (req_ff.mode == MODE_SEARCH) begin
            rsp_in.kind = KIND_MATCH;
            rsp_in.match_position = i_ff + 6'd1;
         end else begin
            rsp_in.kind = KIND_ELEMENT;
            rsp_in.element = rd_data_ff;
         end
      end else begin
         rsp_in.kind = KIND_FINAL;
         rsp_in.status = status_ff;
         rsp_in.count = count_ff;
         rsp_in.last = 1'b1;
         if (req_ff.mode == MODE_MINMAX) begin
            rsp_in.minimum = min_ff;
            rsp_in.maximum = max_ff;
         end
         if (req_ff.mode == MODE_SUM) rsp_in.total = sum_ff;
         if (req_ff.mode == MODE_SEARCH || req_ff.mode == MODE_PRIMES)
            rsp_in.found = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rvalid_ff <= 1'b0;
      else if (cmd.emit_load || cmd.final_load) rvalid_ff <= 1'b1;
      else if (!rsp_stall) rvalid_ff <= 1'b0;
      if (cmd.emit_load || cmd.final_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_word = rsp_ff;

   always_comb begin
      stat.mode = req_ff.mode;
      stat.loaded = loaded_ff;
      stat.full = (count_ff >= 6'(DEPTH));
      stat.pos_bad = (req_ff.position == 6'd0) || (req_ff.position > n);
      stat.i_done = (i_ff >= n);
      stat.i_last_shift = ((i_ff + 6'd1) >= n);
      stat.j_zero = (j_ff == 6'd0);
      stat.j_one = (j_ff == 6'd1);
      stat.move = (req_ff.mode == MODE_SORT_DESC) ? ($signed(rd_data_ff) < $signed(key_ff))
                                                  : ($signed(rd_data_ff) > $signed(key_ff));
      stat.hit = (req_ff.mode == MODE_SEARCH) ? (rd_data_ff == req_ff.value)
                                             : ($signed(rd_data_ff) > 32'sd1);
      stat.prime_done = pdone_ff;
      stat.prime_yes = pres_ff;
      stat.rsp_free = !rvalid_ff || !rsp_stall;
   end
endmodule
`default_nettype wire

/* hw/rtl/ate_control.sv */
// command sequencer of the array table engine
`default_nettype none
module ate_control (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire ate_pkg::stat_type stat,
   output ate_pkg::cmd_type cmd
);
   import ate_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_stall = reset || (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.latch_req = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_FINAL;
            if (stat.mode == MODE_CLEAR) cmd.clear_all = 1'b1;
            else if (stat.mode <= MODE_SORT_ASC) begin
               if (!stat.loaded) begin
                  cmd.set_status = 1'b1; cmd.status = STATUS_NOT_LOADED;
               end else begin
                  unique case (stat.mode)
                     MODE_APPEND: begin
                        if (stat.full) begin
                           cmd.set_status = 1'b1; cmd.status = STATUS_FULL;
                        end else cmd.do_append = 1'b1;
                     end
                     MODE_DELETE: begin
                        if (stat.pos_bad) begin
                           cmd.set_status = 1'b1; cmd.status = STATUS_BAD_POS;
                        end else begin
                           cmd.set_i_pos = 1'b1; state_in = ST_DEL_RD;
                        end
                     end
                     MODE_SORT_DESC, MODE_SORT_ASC: begin
                        cmd.clr_i = 1'b1; state_in = ST_SORT_RDKEY;
                     end
                     default: begin
                        cmd.clr_i = 1'b1; state_in = ST_SCAN_RD;
                     end
                  endcase
               end
            end
         end
         ST_DEL_RD: begin
            if (stat.i_last_shift) begin
               cmd.dec_count = 1'b1; state_in = ST_FINAL;
            end else begin
               cmd.addr_next = 1'b1; state_in = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            cmd.wr_shift = 1'b1; state_in = ST_DEL_RD;
         end
         ST_SCAN_RD: begin
            if (stat.i_done) state_in = ST_FINAL;
            else state_in = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            unique case (stat.mode)
               MODE_MINMAX, MODE_SUM: begin
                  cmd.accum = 1'b1; cmd.inc_i = 1'b1; state_in = ST_SCAN_RD;
               end
               MODE_SEARCH: begin
                  if (stat.hit) state_in = ST_EMIT;
                  else begin cmd.inc_i = 1'b1; state_in = ST_SCAN_RD; end
               end
               MODE_PRIMES: begin
                  if (stat.hit) begin cmd.prime_init = 1'b1; state_in = ST_PRIME_DIV; end
                  else begin cmd.inc_i = 1'b1; state_in = ST_SCAN_RD; end
               end
               default: state_in = ST_EMIT;
            endcase
         end
         ST_PRIME_DIV: begin
            if (stat.prime_done) begin
               if (stat.prime_yes) state_in = ST_EMIT;
               else begin cmd.inc_i = 1'b1; state_in = ST_SCAN_RD; end
            end else cmd.prime_step = 1'b1;
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit_load = 1'b1; cmd.inc_i = 1'b1; state_in = ST_SCAN_RD;
            end
         end
         ST_SORT_RDKEY: begin
            if (stat.i_done) begin cmd.clr_i = 1'b1; state_in = ST_SCAN_RD; end
            else begin cmd.set_j_i = 1'b1; state_in = ST_SORT_RDPREV; end
         end
         ST_SORT_RDPREV: begin
            cmd.sort_key = 1'b1;
            if (stat.j_zero) state_in = ST_SORT_PLACE;
            else begin cmd.set_addr_j1 = 1'b1; state_in = ST_SORT_CMP; end
         end
         ST_SORT_CMP: begin
            if (stat.move) begin
               cmd.sort_move = 1'b1;
               if (stat.j_one) state_in = ST_SORT_PLACE;
               else cmd.set_addr_j2 = 1'b1;
            end else state_in = ST_SORT_PLACE;
         end
         ST_SORT_PLACE: begin
            cmd.sort_place = 1'b1; cmd.inc_i = 1'b1; state_in = ST_SORT_RDKEY;
         end
         ST_FINAL: begin
            if (stat.rsp_free) begin
               cmd.final_load = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* hw/rtl/array_table_engine.sv */
// top level of the array table engine
// usage:
//   req channel takes one command word (mode, value, position) when req_valid
//   is high and req_stall low; req_stall is high during reset and from the
//   acceptance edge until the final word of the command has been loaded.
//   rsp channel returns element or match words first, in array order, then
//   one final word (kind final, last set) with status and summary.
//   clear, append, not-loaded, bad-position and unused commands give only
//   their final word; the next command word can be taken while it is shown.
//   read, sum and minmax scan every element, search emits a word per match,
//   and delete shifts each later element down. the prime list tries each
//   trial divisor in the bit-serial divider. sort is insertion sort, followed
//   by a read of the sorted elements. one command at a time; the one read and
//   one write port of the memory and the divider set the cost.
//   reset empties the array and clears the loaded flag; a clear command is
//   required before any other command succeeds.
//   a stalled rsp word holds and the sequencer waits until it is taken.
`default_nettype none
module array_table_engine #(
   parameter int unsigned DEPTH = ate_pkg::DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire ate_pkg::req_type req_word,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output ate_pkg::rsp_type rsp_word
);
   import ate_pkg::*;
`include "array_table_engine_macros.svh"
   cmd_type cmd;
   stat_type stat;
   logic rsp_final;

   assign rsp_final = (rsp_word.kind == KIND_FINAL);

   ate_control u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .stat(stat), .cmd(cmd)
   );
   ate_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock(clock), .reset(reset), .req_word(req_word), .cmd(cmd), .stat(stat),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   `ATE_ASSERT(a_count_max, clock, reset, (rsp_word.count <= 6'(DEPTH)) || !rsp_valid, "count")
   `ATE_ASSERT(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_word), "word moved")
   `ATE_ASSERT(a_last_final, clock, reset, (rsp_valid && rsp_word.last) |-> rsp_final, "last")
endmodule
`default_nettype wire
